[design/dseq_pkg.sv]
// Shared types, constants and codes for the date-sorted event queue.
`default_nettype none
package dseq_pkg;

	localparam int DEPTH       = 16;
	localparam int TAG_BITS    = 16;
	localparam int MAX_RESULTS = 16;

	localparam int LIST_MAX = (MAX_RESULTS < DEPTH) ? MAX_RESULTS : DEPTH;
	localparam int OCC_W    = $clog2(DEPTH + 1);
	localparam int IDX_W    = $clog2(DEPTH);

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_COUNT  = 2'd1;
	localparam logic [1:0] FUNC_LIST   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [15:0] tag;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  event_count;
		logic [4:0]  out_day;
		logic [3:0]  out_month;
		logic [15:0] out_tag;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [3:0]          month;
		logic [4:0]          day;
		logic [TAG_BITS-1:0] tag;
	} evt_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t   op;
		evt_t       new_evt;
		logic [3:0] cmp_month;
	} cell_ctrl_t;

endpackage
`default_nettype wire

[design/dseq_cell.sv]
// One slot of the sorted event chain, shifting right on insert and left on rotate.
`default_nettype none
module dseq_cell (
	input  wire logic               clk,
	input  wire dseq_pkg::cell_ctrl_t ctrl,
	input  wire logic               live,
	input  wire dseq_pkg::evt_t     left_evt,
	input  wire logic               left_after,
	input  wire dseq_pkg::evt_t     right_evt,
	output dseq_pkg::evt_t          evt,
	output logic                    after,
	output logic                    match
);
	import dseq_pkg::*;

	evt_t evt_q;

	assign evt   = evt_q;
	assign after = !live || ({evt_q.month, evt_q.day} > {ctrl.new_evt.month, ctrl.new_evt.day});
	assign match = live && (evt_q.month == ctrl.cmp_month);

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CELL_INSERT: begin
				if (after) begin
					evt_q <= left_after ? left_evt : ctrl.new_evt;
				end
			end
			CELL_ROTATE: begin
				evt_q <= right_evt;
			end
			default: begin
				evt_q <= evt_q;
			end
		endcase
	end

endmodule
`default_nettype wire

[design/date_sorted_event_queue.sv]
// Top level of the date-sorted event queue: control sequencer and the chain of cells.
//
//   channel | valid     | stall     | payload  | direction
//   request | req_valid | req_stall | req      | into block
//   response| rsp_valid | rsp_stall | rsp      | out of block
//
// Insert and an empty list answer from EXEC; count registers the month matches and then
// answers from CNT; a list rotates the whole cell chain, one cell per cycle unless stalled.
// One request is worked on at a time; a new request is taken while a response still waits.
// Output stalls hold the chain during the listing of stored events.
// Reset clears the occupancy and control state; event slots are not cleared.
`default_nettype none
module date_sorted_event_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire dseq_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output dseq_pkg::rsp_t      rsp
);
	import dseq_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		EXEC,
		CNT,
		LIST
	} state_t;

	state_t           state_q;
	req_t             req_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;
	logic [OCC_W-1:0] occ_q;
	logic [IDX_W-1:0] k_q;
	logic [DEPTH-1:0] match_s1;

	cell_ctrl_t       ctrl;
	evt_t             cell_evt [DEPTH];
	logic [DEPTH-1:0] cell_after;
	logic [DEPTH-1:0] cell_match;

	logic             out_free;
	logic             full;
	logic [OCC_W-1:0] list_n;
	logic             list_emit;
	logic             list_step;
	logic             rsp_load;

	assign req_stall = (state_q != IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign full      = (occ_q == OCC_W'(DEPTH));
	assign list_n    = (occ_q > OCC_W'(LIST_MAX)) ? OCC_W'(LIST_MAX) : occ_q;
	assign list_emit = (OCC_W'(k_q) < list_n);
	assign list_step = !list_emit || out_free;
	assign rsp_load  = out_free && (
		(state_q == EXEC && (req_q.func == FUNC_INSERT ||
		                     (req_q.func == FUNC_LIST && occ_q == '0))) ||
		state_q == CNT || (state_q == LIST && list_emit));

	function automatic rsp_t rsp_of(logic [1:0] status, logic [4:0] cnt, evt_t e, logic last);
		rsp_t r;
		r.status      = status;
		r.event_count = cnt;
		r.out_day     = e.day;
		r.out_month   = e.month;
		r.out_tag     = 16'(e.tag);
		r.last        = last;
		return r;
	endfunction

	always_comb begin
		ctrl.op            = CELL_HOLD;
		ctrl.new_evt.month = req_q.month;
		ctrl.new_evt.day   = req_q.day;
		ctrl.new_evt.tag   = TAG_BITS'(req_q.tag);
		ctrl.cmp_month     = req_q.month;
		if (state_q == EXEC && req_q.func == FUNC_INSERT && out_free && !full) begin
			ctrl.op = CELL_INSERT;
		end else if (state_q == LIST && list_step) begin
			ctrl.op = CELL_ROTATE;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		evt_t left_evt;
		logic left_after;
		evt_t right_evt;
		logic live;

		assign live = (OCC_W'(i) < occ_q);

		if (i == 0) begin : g_first
			assign left_evt   = ctrl.new_evt;
			assign left_after = 1'b0;
		end else begin : g_inner
			assign left_evt   = cell_evt[i-1];
			assign left_after = cell_after[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_evt = cell_evt[0];
		end else begin : g_mid
			assign right_evt = cell_evt[i+1];
		end

		dseq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.live       (live),
			.left_evt   (left_evt),
			.left_after (left_after),
			.right_evt  (right_evt),
			.evt        (cell_evt[i]),
			.after      (cell_after[i]),
			.match      (cell_match[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			rsp_valid_q <= 1'b0;
			occ_q       <= '0;
			k_q         <= '0;
			req_q       <= '0;
			rsp_q       <= '0;
			match_s1    <= '0;
		end else begin
			if (out_free) begin
				rsp_valid_q <= rsp_load;
			end
			unique case (state_q)
				IDLE: begin
					if (req_valid) begin
						req_q <= req;
						if (req.func == FUNC_INSERT || req.func == FUNC_COUNT ||
						    req.func == FUNC_LIST) begin
							state_q <= EXEC;
						end
					end
				end
				EXEC: begin
					priority if (req_q.func == FUNC_INSERT) begin
						if (out_free) begin
							rsp_q       <= rsp_of(full ? ST_FULL : ST_OK, 5'd0, '0, 1'b1);
							if (!full) begin
								occ_q <= occ_q + OCC_W'(1);
							end
							state_q <= IDLE;
						end
					end else if (req_q.func == FUNC_COUNT) begin
						match_s1 <= cell_match;
						state_q  <= CNT;
					end else begin
						if (occ_q == '0) begin
							if (out_free) begin
								rsp_q       <= rsp_of(ST_EMPTY, 5'd0, '0, 1'b1);
								state_q     <= IDLE;
							end
						end else begin
							k_q     <= '0;
							state_q <= LIST;
						end
					end
				end
				CNT: begin
					if (out_free) begin
						rsp_q       <= rsp_of(ST_OK, 5'($countones(match_s1)), '0, 1'b1);
						state_q     <= IDLE;
					end
				end
				LIST: begin
					if (list_step) begin
						if (list_emit) begin
							rsp_q       <= rsp_of(ST_OK, 5'd0, cell_evt[0],
							                      OCC_W'(k_q) == list_n - OCC_W'(1));
						end
						if (k_q == IDX_W'(DEPTH - 1)) begin
							state_q <= IDLE;
						end else begin
							k_q <= k_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[design/dseq_checker.sv]
// Port-level checker for the date-sorted event queue, bound to the top level.
`default_nettype none
module dseq_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire dseq_pkg::req_t req,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire dseq_pkg::rsp_t rsp
);
	import dseq_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled response transaction changed or dropped.");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall &&
		(req.func == FUNC_INSERT || req.func == FUNC_COUNT || req.func == FUNC_LIST)
		|=> req_stall)
		else $error("Block took a new request while the previous one was in progress.");

	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |->
		rsp.last && rsp.event_count == 5'd0 && rsp.out_month == 4'd0 &&
		rsp.out_day == 5'd0 && rsp.out_tag == 16'd0)
		else $error("Full or empty status response was not a single cleared result.");

	a_count_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.event_count != 5'd0 |-> rsp.last && rsp.out_month == 4'd0)
		else $error("Count response was not a single final result.");

endmodule

bind date_sorted_event_queue dseq_checker u_dseq_checker (.*);
`default_nettype wire
